### rtl/core/srfp_pkg.sv
// shared types, constants and helper functions of the response frame parser
`default_nettype none

package srfp_pkg;

	localparam int FRAME_BYTES_DEF = 64;
	localparam logic [3:0] TOKEN_LIMIT = 4'd10;

	localparam logic [7:0] CARET_BYTE = 8'h5E;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_K = 8'h4B;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_W = 8'h57;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	localparam logic [7:0] START_RST = 8'h24;
	localparam logic [7:0] END_RST = 8'h0D;
	localparam logic [7:0] MARKER_RST = 8'h3A;

	typedef enum logic [1:0] {
		CFG_START  = 2'd0,
		CFG_END    = 2'd1,
		CFG_MARKER = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_NK       = 3'd1,
		STS_ASYNC    = 3'd2,
		STS_INVALID  = 3'd3,
		STS_BAD_CHK  = 3'd4,
		STS_BAD_SEQ  = 3'd5,
		STS_OVERFLOW = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SEQ_NONE   = 2'd0,
		SEQ_MARKER = 2'd1,
		SEQ_DIGIT  = 2'd2,
		SEQ_DONE   = 2'd3
	} seq_phase_t;

	// first token matcher
	typedef enum logic [11:0] {
		M_START  = 12'b0000_0000_0001,
		M_DOLLAR = 12'b0000_0000_0010,
		M_O      = 12'b0000_0000_0100,
		M_N      = 12'b0000_0000_1000,
		M_W      = 12'b0000_0001_0000,
		M_S      = 12'b0000_0010_0000,
		M_ASYNC  = 12'b0000_0100_0000,
		M_OK     = 12'b0000_1000_0000,
		M_NK     = 12'b0001_0000_0000,
		M_WF     = 12'b0010_0000_0000,
		M_ST     = 12'b0100_0000_0000,
		M_BAD    = 12'b1000_0000_0000
	} match_t;

	typedef struct packed {
		logic [7:0] run_xor;
		logic       caret;
		logic [1:0] chk_n;
		logic [7:0] chk_val;
		logic       chk_bad;
		match_t     match;
		logic [3:0] tok_cnt;
		seq_phase_t seq_phase;
		logic [7:0] seq_val;
		logic       space_pend;
		logic       scan_stop;
	} frame_st_t;

	localparam frame_st_t FRAME_CLEAR = '{
		run_xor: 8'd0,
		caret: 1'b0,
		chk_n: 2'd0,
		chk_val: 8'd0,
		chk_bad: 1'b0,
		match: M_START,
		tok_cnt: 4'd0,
		seq_phase: SEQ_NONE,
		seq_val: 8'd0,
		space_pend: 1'b0,
		scan_stop: 1'b0
	};

	// upper bit flags a byte that is not an uppercase hex digit
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= CH_0 && c <= CH_9) begin
				d = c - CH_0;
				hex_of = {1'b0, d[3:0]};
			end else if (c >= CH_A && c <= CH_F) begin
				d = c - CH_A + 8'd10;
				hex_of = {1'b0, d[3:0]};
			end else begin
				hex_of = 5'b10000;
			end
		end
	endfunction

	function automatic match_t match_next(input match_t st, input logic [7:0] c);
		begin
			unique case (st)
				M_START: match_next = (c == CH_DOLLAR) ? M_DOLLAR : M_BAD;
				M_DOLLAR: begin
					if (c == CH_O) match_next = M_O;
					else if (c == CH_N) match_next = M_N;
					else if (c == CH_W) match_next = M_W;
					else if (c == CH_S) match_next = M_S;
					else if (c == CH_A) match_next = M_ASYNC;
					else match_next = M_BAD;
				end
				M_O: match_next = (c == CH_K) ? M_OK : M_BAD;
				M_N: match_next = (c == CH_K) ? M_NK : M_BAD;
				M_W: match_next = (c == CH_F) ? M_WF : M_BAD;
				M_S: match_next = (c == CH_T) ? M_ST : M_BAD;
				M_ASYNC: match_next = M_ASYNC;
				default: match_next = M_BAD;
			endcase
		end
	endfunction

endpackage

`default_nettype wire

### rtl/core/srfp_parse.sv
// per-byte next-state and status logic of the response frame parser
`default_nettype none

module srfp_parse #(
	parameter int FRAME_BYTES = srfp_pkg::FRAME_BYTES_DEF
) (
	input  wire logic [7:0]                     start_byte,
	input  wire logic [7:0]                     end_byte,
	input  wire logic [7:0]                     marker_byte,
	input  wire logic [7:0]                     c,
	input  wire logic [7:0]                     expected,
	input  wire logic [$clog2(FRAME_BYTES)-1:0] pos,
	input  wire srfp_pkg::frame_st_t            st,
	input  wire logic [15:0]                    ok_cnt,
	input  wire logic                           link,
	output logic [$clog2(FRAME_BYTES)-1:0]      pos_nxt,
	output srfp_pkg::frame_st_t                 st_nxt,
	output logic [15:0]                         ok_nxt,
	output logic                                link_nxt,
	output logic                                fire,
	output srfp_pkg::status_t                   status
);

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	logic [4:0]       hx;
	logic [4:0]       chk_hx;
	logic [POS_W-1:0] pos_inc;
	logic [3:0]       tc;
	logic [7:0]       rchk;
	logic             at_first;

	assign hx = srfp_pkg::hex_of(c);
	assign chk_hx = hx;
	assign pos_inc = pos + POS_W'(1);
	assign tc = st.tok_cnt + 4'd1;
	assign rchk = st.chk_bad ? 8'd0 : st.chk_val;
	assign at_first = (pos == '0);

	always_comb begin
		pos_nxt = pos;
		st_nxt = st;
		ok_nxt = ok_cnt;
		link_nxt = link;
		fire = 1'b0;
		status = srfp_pkg::STS_INVALID;

		if (at_first && c != start_byte) begin
			// idle, byte skipped
		end else if (!at_first && c == end_byte) begin
			fire = 1'b1;
			pos_nxt = '0;
			st_nxt = srfp_pkg::FRAME_CLEAR;
			if (st.caret && rchk != st.run_xor) begin
				status = srfp_pkg::STS_BAD_CHK;
			end else if (st.seq_phase != srfp_pkg::SEQ_NONE && st.seq_val != expected) begin
				status = srfp_pkg::STS_BAD_SEQ;
			end else if (st.tok_cnt == 4'd0) begin
				status = srfp_pkg::STS_INVALID;
			end else begin
				case (st.match)
					srfp_pkg::M_OK: begin
						status = srfp_pkg::STS_OK;
						ok_nxt = ok_cnt + 16'd1;
						link_nxt = 1'b1;
					end
					srfp_pkg::M_NK: status = srfp_pkg::STS_NK;
					srfp_pkg::M_WF, srfp_pkg::M_ST, srfp_pkg::M_ASYNC:
						status = srfp_pkg::STS_ASYNC;
					default: status = srfp_pkg::STS_INVALID;
				endcase
			end
		end else begin
			if (!st.caret) begin
				if (c == srfp_pkg::CARET_BYTE) begin
					st_nxt.caret = 1'b1;
				end else begin
					st_nxt.run_xor = st.run_xor ^ c;
					if (st.seq_phase == srfp_pkg::SEQ_MARKER ||
					    st.seq_phase == srfp_pkg::SEQ_DIGIT) begin
						if (hx[4]) begin
							st_nxt.seq_val = 8'd0;
							st_nxt.seq_phase = srfp_pkg::SEQ_DONE;
						end else begin
							st_nxt.seq_val = {st.seq_val[3:0], hx[3:0]};
							st_nxt.seq_phase = (st.seq_phase == srfp_pkg::SEQ_MARKER) ?
								srfp_pkg::SEQ_DIGIT : srfp_pkg::SEQ_DONE;
						end
					end else if (st.seq_phase == srfp_pkg::SEQ_DONE) begin
						// sequence id complete, rest of scan frozen
					end else if (st.scan_stop) begin
						if (st.tok_cnt == 4'd1) st_nxt.match = srfp_pkg::match_next(st.match, c);
					end else if (at_first || st.space_pend) begin
						// first byte of a token counts as a token byte whatever it is
						st_nxt.space_pend = 1'b0;
						st_nxt.tok_cnt = tc;
						if (tc == 4'd1) st_nxt.match = srfp_pkg::match_next(st.match, c);
						if (tc >= srfp_pkg::TOKEN_LIMIT) st_nxt.scan_stop = 1'b1;
					end else if (c == srfp_pkg::SPACE_BYTE) begin
						st_nxt.space_pend = 1'b1;
					end else if (c == marker_byte) begin
						st_nxt.seq_phase = srfp_pkg::SEQ_MARKER;
					end else if (st.tok_cnt == 4'd1) begin
						st_nxt.match = srfp_pkg::match_next(st.match, c);
					end
				end
			end else if (st.chk_n < 2'd2 && !st.chk_bad) begin
				if (chk_hx[4]) begin
					st_nxt.chk_bad = 1'b1;
				end else begin
					st_nxt.chk_val = {st.chk_val[3:0], chk_hx[3:0]};
					st_nxt.chk_n = st.chk_n + 2'd1;
				end
			end

			if (pos_inc == POS_LAST) begin
				fire = 1'b1;
				status = srfp_pkg::STS_OVERFLOW;
				pos_nxt = '0;
				st_nxt = srfp_pkg::FRAME_CLEAR;
			end else begin
				pos_nxt = pos_inc;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/serial_response_frame_parser_core.sv
// Parser for framed serial response lines, one received byte per item.
// Input channel: in_valid / in_stall with rx_byte and expected_sequence.
// Output channel: out_valid / out_stall with status, link_up and ok_total; one
// result per end byte of a frame or per frame that grows too long, none else.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (0 start byte, 1 end byte, 2 sequence marker); write only while idle.
// A result passes from the input register through the parse logic into the
// result register.
// Throughput: one byte per cycle while the result register is not stalled; the
// parse logic between the input register and the result register is combinational.
// A stalled result is held in the result register; the input register takes
// at most one more byte, then in_stall rises until the result is taken.
// Reset clears the frame state, the OK counter and the link flag, and loads
// the default start, end and marker bytes; the parser then waits for a start
// byte, skipping everything else.
`default_nettype none

module serial_response_frame_parser_core #(
	parameter int FRAME_BYTES = srfp_pkg::FRAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  expected_sequence,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic             link_up,
	output logic [15:0]      ok_total
);

	localparam int POS_W = $clog2(FRAME_BYTES);

	logic [7:0] start_q;
	logic [7:0] end_q;
	logic [7:0] marker_q;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic [7:0] expected_s1;

	logic [POS_W-1:0]    pos_q;
	srfp_pkg::frame_st_t st_q;
	logic [15:0]         ok_cnt_q;
	logic                link_q;

	logic [POS_W-1:0]    pos_nxt;
	srfp_pkg::frame_st_t st_nxt;
	logic [15:0]         ok_nxt;
	logic                link_nxt;
	logic                fire;
	srfp_pkg::status_t   status_nxt;

	logic              out_valid_q;
	srfp_pkg::status_t status_q;
	logic              link_up_q;
	logic [15:0]       ok_total_q;

	logic advance;
	logic step;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= srfp_pkg::START_RST;
			end_q <= srfp_pkg::END_RST;
			marker_q <= srfp_pkg::MARKER_RST;
		end else if (cfg_we) begin
			unique case (srfp_pkg::cfg_idx_t'(cfg_index))
				srfp_pkg::CFG_START: start_q <= cfg_data;
				srfp_pkg::CFG_END: end_q <= cfg_data;
				srfp_pkg::CFG_MARKER: marker_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
			expected_s1 <= expected_sequence;
		end
	end

	srfp_parse #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_parse (
		.start_byte (start_q),
		.end_byte   (end_q),
		.marker_byte(marker_q),
		.c          (rx_byte_s1),
		.expected   (expected_s1),
		.pos        (pos_q),
		.st         (st_q),
		.ok_cnt     (ok_cnt_q),
		.link       (link_q),
		.pos_nxt    (pos_nxt),
		.st_nxt     (st_nxt),
		.ok_nxt     (ok_nxt),
		.link_nxt   (link_nxt),
		.fire       (fire),
		.status     (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			st_q <= srfp_pkg::FRAME_CLEAR;
			ok_cnt_q <= 16'd0;
			link_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_nxt;
			st_q <= st_nxt;
			ok_cnt_q <= ok_nxt;
			link_q <= link_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (step && fire) begin
			status_q <= status_nxt;
			link_up_q <= link_nxt;
			ok_total_q <= ok_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign link_up = link_up_q;
	assign ok_total = ok_total_q;

endmodule

`default_nettype wire

### test/tb_serial_response_frame_parser_core.sv
// testbench for the serial response frame parser: directed and random frames checked per result
`timescale 1ns / 100ps

module tb_serial_response_frame_parser_core;

	typedef struct packed {
		srfp_pkg::status_t sts;
		logic              up;
		logic [15:0]       cnt;
	} resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = srfp_pkg::CFG_START;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic [7:0]  expected_sequence = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic        link_up;
	logic [15:0] ok_total;

	serial_response_frame_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.expected_sequence(expected_sequence),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.link_up(link_up),
		.ok_total(ok_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the registers and the frame state
	logic [7:0]            cfg_start, cfg_end, cfg_marker;
	int unsigned           frame_len;
	logic [7:0]            xor_acc;
	bit                    after_caret;
	int                    chk_digits;
	logic [7:0]            chk_acc;
	bit                    chk_invalid;
	srfp_pkg::match_t      head_match;
	int                    tokens;
	srfp_pkg::seq_phase_t  seq_ph;
	logic [7:0]            seq_acc;
	logic [15:0]           ok_count;
	bit                    link_flag;
	bit                    gap_pending;
	bit                    scan_done;

	resp_t       pending_resps[$];
	logic [7:0]  frame_buf[$];
	bit          idle_on = 1'b1;
	int          errors = 0;
	int          n_bytes = 0;
	int          n_frames = 0;
	int          n_results = 0;
	int          n_writes = 0;

	function automatic int hexval(logic [7:0] c);
		if (c >= srfp_pkg::CH_0 && c <= srfp_pkg::CH_9)
			return c - srfp_pkg::CH_0;
		if (c >= srfp_pkg::CH_A && c <= srfp_pkg::CH_F)
			return c - srfp_pkg::CH_A + 10;
		return -1;
	endfunction

	function automatic srfp_pkg::match_t next_match(srfp_pkg::match_t st, logic [7:0] c);
		case (st)
			srfp_pkg::M_START:
				return (c == srfp_pkg::CH_DOLLAR) ? srfp_pkg::M_DOLLAR : srfp_pkg::M_BAD;
			srfp_pkg::M_DOLLAR: begin
				if (c == srfp_pkg::CH_O) return srfp_pkg::M_O;
				if (c == srfp_pkg::CH_N) return srfp_pkg::M_N;
				if (c == srfp_pkg::CH_W) return srfp_pkg::M_W;
				if (c == srfp_pkg::CH_S) return srfp_pkg::M_S;
				if (c == srfp_pkg::CH_A) return srfp_pkg::M_ASYNC;
				return srfp_pkg::M_BAD;
			end
			srfp_pkg::M_O: return (c == srfp_pkg::CH_K) ? srfp_pkg::M_OK : srfp_pkg::M_BAD;
			srfp_pkg::M_N: return (c == srfp_pkg::CH_K) ? srfp_pkg::M_NK : srfp_pkg::M_BAD;
			srfp_pkg::M_W: return (c == srfp_pkg::CH_F) ? srfp_pkg::M_WF : srfp_pkg::M_BAD;
			srfp_pkg::M_S: return (c == srfp_pkg::CH_T) ? srfp_pkg::M_ST : srfp_pkg::M_BAD;
			srfp_pkg::M_ASYNC: return srfp_pkg::M_ASYNC;
			default: return srfp_pkg::M_BAD;
		endcase
	endfunction

	function automatic void drop_frame();
		frame_len = 0;
		xor_acc = 8'd0;
		after_caret = 1'b0;
		chk_digits = 0;
		chk_acc = 8'd0;
		chk_invalid = 1'b0;
		head_match = srfp_pkg::M_START;
		tokens = 0;
		seq_ph = srfp_pkg::SEQ_NONE;
		seq_acc = 8'd0;
		gap_pending = 1'b0;
		scan_done = 1'b0;
	endfunction

	function automatic void pred_reset();
		cfg_start = srfp_pkg::START_RST;
		cfg_end = srfp_pkg::END_RST;
		cfg_marker = srfp_pkg::MARKER_RST;
		ok_count = 16'd0;
		link_flag = 1'b0;
		drop_frame();
	endfunction

	function automatic void scan_token_byte(logic [7:0] c);
		int d;
		if (seq_ph == srfp_pkg::SEQ_MARKER || seq_ph == srfp_pkg::SEQ_DIGIT) begin
			d = hexval(c);
			if (d < 0) begin
				seq_acc = 8'd0;
				seq_ph = srfp_pkg::SEQ_DONE;
			end else begin
				seq_acc = {seq_acc[3:0], d[3:0]};
				seq_ph = (seq_ph == srfp_pkg::SEQ_MARKER) ?
					srfp_pkg::SEQ_DIGIT : srfp_pkg::SEQ_DONE;
			end
			return;
		end
		if (seq_ph == srfp_pkg::SEQ_DONE)
			return;
		if (scan_done) begin
			if (tokens == 1)
				head_match = next_match(head_match, c);
			return;
		end
		// first byte of a token counts as token content, whatever it is
		if (frame_len == 0 || gap_pending) begin
			gap_pending = 1'b0;
			tokens++;
			if (tokens == 1)
				head_match = next_match(head_match, c);
			if (tokens >= srfp_pkg::TOKEN_LIMIT)
				scan_done = 1'b1;
			return;
		end
		if (c == srfp_pkg::SPACE_BYTE)
			gap_pending = 1'b1;
		else if (c == cfg_marker)
			seq_ph = srfp_pkg::SEQ_MARKER;
		else if (tokens == 1)
			head_match = next_match(head_match, c);
	endfunction

	function automatic void absorb_byte(logic [7:0] c);
		int d;
		if (!after_caret) begin
			if (c == srfp_pkg::CARET_BYTE) begin
				after_caret = 1'b1;
			end else begin
				xor_acc ^= c;
				scan_token_byte(c);
			end
		end else if (chk_digits < 2 && !chk_invalid) begin
			d = hexval(c);
			if (d < 0) begin
				chk_invalid = 1'b1;
			end else begin
				chk_acc = {chk_acc[3:0], d[3:0]};
				chk_digits++;
			end
		end
	endfunction

	function automatic srfp_pkg::status_t close_status(logic [7:0] sid);
		logic [7:0] rx_chk;
		rx_chk = chk_invalid ? 8'd0 : chk_acc;
		if (after_caret && rx_chk != xor_acc)
			return srfp_pkg::STS_BAD_CHK;
		if (seq_ph != srfp_pkg::SEQ_NONE && seq_acc != sid)
			return srfp_pkg::STS_BAD_SEQ;
		if (tokens == 0)
			return srfp_pkg::STS_INVALID;
		case (head_match)
			srfp_pkg::M_OK: begin
				ok_count++;
				link_flag = 1'b1;
				return srfp_pkg::STS_OK;
			end
			srfp_pkg::M_NK: return srfp_pkg::STS_NK;
			srfp_pkg::M_WF, srfp_pkg::M_ST, srfp_pkg::M_ASYNC: return srfp_pkg::STS_ASYNC;
			default: return srfp_pkg::STS_INVALID;
		endcase
	endfunction

	function automatic bit predict_byte(logic [7:0] c, logic [7:0] sid, output resp_t r);
		srfp_pkg::status_t st;
		r = '0;
		if (frame_len == 0 && c != cfg_start)
			return 1'b0;
		if (frame_len != 0 && c == cfg_end) begin
			st = close_status(sid);
			drop_frame();
		end else begin
			absorb_byte(c);
			frame_len++;
			if (frame_len < srfp_pkg::FRAME_BYTES_DEF - 1)
				return 1'b0;
			st = srfp_pkg::STS_OVERFLOW;
			drop_frame();
		end
		r.sts = st;
		r.up = link_flag;
		r.cnt = ok_count;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 50)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(negedge clk)
		out_stall <= idle_on && ($urandom_range(99) < 38);

	always @(posedge clk) begin : result_monitor
		resp_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_resps.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d", status));
			end else begin
				want = pending_resps.pop_front();
				if (status !== want.sts)
					report_mismatch($sformatf("status %0d, want %0d", status, want.sts));
				if (link_up !== want.up)
					report_mismatch($sformatf("link_up %0b, want %0b", link_up, want.up));
				if (ok_total !== want.cnt)
					report_mismatch($sformatf("ok_total %0d, want %0d", ok_total, want.cnt));
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic [7:0] sid);
		resp_t r;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		expected_sequence <= sid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (predict_byte(b, sid, r))
			pending_resps.push_back(r);
		n_bytes++;
	endtask

	// wait until every expected result is in, then let the pipeline empty
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_resps.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_resps.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_resps.size()));
			pending_resps.delete();
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input srfp_pkg::cfg_idx_t idx, input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			srfp_pkg::CFG_START: cfg_start = v;
			srfp_pkg::CFG_END: cfg_end = v;
			default: cfg_marker = v;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		n_writes++;
	endtask

	task automatic set_regs(input logic [7:0] s, input logic [7:0] e, input logic [7:0] m);
		settle();
		write_reg(srfp_pkg::CFG_START, s);
		write_reg(srfp_pkg::CFG_END, e);
		write_reg(srfp_pkg::CFG_MARKER, m);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 10)
			return srfp_pkg::CH_0 + n;
		return (lower ? 8'h61 : srfp_pkg::CH_A) + n - 8'd10;
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			frame_buf.push_back(s[i]);
	endfunction

	function automatic void start_frame(string rest);
		frame_buf.delete();
		frame_buf.push_back(cfg_start);
		put_str(rest);
	endfunction

	function automatic void add_check(bit good);
		logic [7:0] x;
		x = 8'd0;
		foreach (frame_buf[i])
			x ^= frame_buf[i];
		if (!good)
			x = x ^ (8'd1 << $urandom_range(7));
		frame_buf.push_back(srfp_pkg::CARET_BYTE);
		frame_buf.push_back(hex_char(x[7:4], 1'b0));
		frame_buf.push_back(hex_char(x[3:0], 1'b0));
	endfunction

	task automatic send_frame(input logic [7:0] sid, input bit closed = 1'b1);
		if (closed)
			frame_buf.push_back(cfg_end);
		foreach (frame_buf[i])
			send_byte(frame_buf[i], (i == frame_buf.size() - 1) ? sid : 8'($urandom));
		n_frames++;
	endtask

	function automatic logic [7:0] tok_char();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return srfp_pkg::CH_A + 8'($urandom_range(25));
		if (r < 90)
			return srfp_pkg::CH_0 + 8'($urandom_range(9));
		return 8'($urandom);
	endfunction

	function automatic void put_token(int lo, int hi);
		int n;
		n = $urandom_range(hi, lo);
		repeat (n) frame_buf.push_back(tok_char());
	endfunction

	// frame with random content; sid is the id to present on the end byte
	function automatic void build_random_frame(output logic [7:0] sid);
		int k;
		int extra;
		logic [7:0] id;
		k = $urandom_range(99);
		sid = 8'($urandom);
		if (k < 30) start_frame("OK");
		else if (k < 45) start_frame("NK");
		else if (k < 55) start_frame("WF");
		else if (k < 65) start_frame("ST");
		else if (k < 78) begin
			start_frame("A");
			put_token(0, 3);
		end else begin
			start_frame("");
			put_token(0, 4);
		end
		extra = ($urandom_range(99) < 15) ? $urandom_range(12, 8) : $urandom_range(3);
		repeat (extra) begin
			frame_buf.push_back(srfp_pkg::SPACE_BYTE);
			put_token(1, 4);
		end
		if ($urandom_range(99) < 40) begin
			id = 8'($urandom);
			frame_buf.push_back(cfg_marker);
			k = $urandom_range(99);
			if (k < 80) begin
				frame_buf.push_back(hex_char(id[7:4], 1'b0));
				frame_buf.push_back(hex_char(id[3:0], 1'b0));
			end else if (k < 90) begin
				frame_buf.push_back(hex_char(id[3:0], 1'b0));
				id = {4'd0, id[3:0]};
			end else begin
				frame_buf.push_back(hex_char(id[7:4], 1'b1));
				frame_buf.push_back(hex_char(id[3:0], 1'b1));
			end
			if ($urandom_range(99) < 80)
				sid = id;
		end
		if ($urandom_range(99) < 50) begin
			k = $urandom_range(99);
			if (k < 85) begin
				add_check(1'b1);
			end else if (k < 92) begin
				add_check(1'b0);
			end else begin
				frame_buf.push_back(srfp_pkg::CARET_BYTE);
				frame_buf.push_back(hex_char(4'($urandom), 1'b1));
			end
			if ($urandom_range(99) < 20)
				put_token(1, 3);
		end
	endfunction

	task automatic run_random(input int count);
		int target;
		int k;
		logic [7:0] sid;
		target = n_bytes + count;
		while (n_bytes < target) begin
			k = $urandom_range(99);
			if (k < 8) begin
				repeat ($urandom_range(6, 1)) send_byte(8'($urandom), 8'($urandom));
			end else if (k < 12) begin
				start_frame("OK");
				put_token(60, 70);
				send_frame(8'($urandom));
			end else begin
				build_random_frame(sid);
				// a few frames are cut short and run into the next one
				send_frame(sid, $urandom_range(99) >= 4);
			end
		end
	endtask

	task automatic test_responses();
		send_byte(cfg_end, 8'h00);
		send_byte(8'h00, 8'hFF);
		send_byte(8'hFF, 8'h00);
		start_frame("OK"); send_frame(8'($urandom));
		start_frame("NK"); send_frame(8'($urandom));
		start_frame("WF"); send_frame(8'($urandom));
		start_frame("ST"); send_frame(8'($urandom));
		start_frame("AEVT"); send_frame(8'($urandom));
		start_frame("XY"); send_frame(8'($urandom));
		start_frame(""); send_frame(8'($urandom));
		start_frame("OKX"); send_frame(8'($urandom));
		// zero byte is plain frame content
		start_frame("NK"); frame_buf.push_back(8'h00); send_frame(8'($urandom));
	endtask

	task automatic test_checksum();
		start_frame("OK"); add_check(1'b1); send_frame(8'h00);
		start_frame("NK"); add_check(1'b0); send_frame(8'h00);
		start_frame("ST^ab"); send_frame(8'h00);
		start_frame("OK^5"); send_frame(8'h00);
		start_frame("WF^"); send_frame(8'h00);
		start_frame("OK"); add_check(1'b1); put_str("ZZ9"); send_frame(8'h00);
	endtask

	task automatic test_sequence();
		start_frame("OK :1F"); send_frame(8'h1F);
		start_frame("OK :1F"); send_frame(8'h1E);
		start_frame("NK :7"); send_frame(8'h07);
		start_frame("OK :G1"); send_frame(8'h00);
		start_frame("OK ::5"); send_frame(8'h05);
		start_frame("OK:2a"); add_check(1'b1); send_frame(8'h2A);
		start_frame("OK:FF"); add_check(1'b1); send_frame(8'hFF);
	endtask

	task automatic test_token_scan();
		start_frame("OK  X"); send_frame(8'h00);
		start_frame("OK A B C D E F G H I J K :99"); send_frame(8'h00);
		start_frame("A B :3C"); send_frame(8'h3C);
	endtask

	task automatic test_overflow();
		start_frame("OK");
		repeat (59) frame_buf.push_back(srfp_pkg::CH_A);
		send_frame(8'h00);
		start_frame("OK");
		repeat (60) frame_buf.push_back(srfp_pkg::CH_A);
		send_frame(8'h00);
	endtask

	task automatic test_register_extremes();
		logic [7:0] sid;
		// marker equal to a space: the space wins
		set_regs(srfp_pkg::START_RST, srfp_pkg::END_RST, srfp_pkg::SPACE_BYTE);
		start_frame("OK 12"); send_frame(8'h12);
		repeat (4) begin
			build_random_frame(sid);
			send_frame(sid);
		end
		// start byte equal to the caret: empty content
		set_regs(srfp_pkg::CARET_BYTE, srfp_pkg::END_RST, srfp_pkg::MARKER_RST);
		start_frame(""); send_frame(8'h00);
		start_frame("00"); send_frame(8'h00);
		start_frame("5"); send_frame(8'h00);
		set_regs(8'h00, 8'hFF, 8'hFF);
		repeat (6) begin
			build_random_frame(sid);
			send_frame(sid);
		end
		set_regs(8'hFF, 8'h00, 8'h00);
		repeat (6) begin
			build_random_frame(sid);
			send_frame(sid);
		end
		set_regs(srfp_pkg::START_RST, srfp_pkg::END_RST, srfp_pkg::MARKER_RST);
	endtask

	task automatic test_random_traffic();
		idle_on = 1'b1;
		run_random(180);
		settle();
		idle_on = 1'b0;
		run_random(100);
		settle();
		idle_on = 1'b1;
		repeat (3) begin
			set_regs(($urandom_range(1)) ? srfp_pkg::CH_DOLLAR : 8'($urandom),
				($urandom_range(1)) ? srfp_pkg::END_RST : 8'($urandom),
				($urandom_range(1)) ? srfp_pkg::MARKER_RST : 8'($urandom));
			run_random(50);
		end
		set_regs(srfp_pkg::START_RST, srfp_pkg::END_RST, srfp_pkg::MARKER_RST);
		run_random(50);
	endtask

	initial begin
		pred_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_responses();
		test_checksum();
		test_sequence();
		test_token_scan();
		test_overflow();
		test_register_extremes();
		test_random_traffic();
		settle();
		$display("covered %0d bytes in %0d frames, %0d results checked, %0d register writes",
			n_bytes, n_frames, n_results, n_writes);
		$display("responses, checksum, sequence id, token scan, overflow, register extremes, random");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
